@@ rtl/plc_pkg.sv @@
// Package for the proximity lid controller: item types, mode and command codes, register map and reset values.
package plc_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_CONFIRM = 3'd1,
        MODE_OPEN    = 3'd2,
        MODE_CLOSING = 3'd3,
        MODE_FORCED  = 3'd4
    } lid_mode_t;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_OPEN  = 2'd1,
        CMD_CLOSE = 2'd2
    } cmd_t;

    localparam logic [2:0] REG_PRESENCE_LOW  = 3'd0;
    localparam logic [2:0] REG_PRESENCE_HIGH = 3'd1;
    localparam logic [2:0] REG_CONFIRM_COUNT = 3'd2;
    localparam logic [2:0] REG_HOLD_TICKS    = 3'd3;
    localparam logic [2:0] REG_DUTY_OPEN     = 3'd4;
    localparam logic [2:0] REG_DUTY_CLOSED   = 3'd5;

    localparam logic [7:0] PRESENCE_LOW_RST  = 8'd2;
    localparam logic [7:0] PRESENCE_HIGH_RST = 8'd30;
    localparam logic [7:0] CONFIRM_COUNT_RST = 8'd3;
    localparam logic [7:0] HOLD_TICKS_RST    = 8'd100;
    localparam logic [9:0] DUTY_OPEN_RST     = 10'd100;
    localparam logic [9:0] DUTY_CLOSED_RST   = 10'd25;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] distance;
        logic [7:0] fill_distance_in;
    } in_item_t;

    typedef struct packed {
        logic [9:0] servo_duty;
        logic       notify_open;
        logic       fill_report_valid;
        logic [7:0] fill_distance_out;
        logic [2:0] mode;
    } out_item_t;

endpackage

@@ rtl/proximity_lid_controller.sv @@
// Proximity lid controller: command handling, five-mode lid machine and result register.
//
// One item per control tick. Each accepted item first applies its remote command
// (force open, close), then steps the lid machine once: idle waits for a
// distance strictly inside the presence window, confirm counts down a run of
// in-range samples, open holds the lid and reloads the hold timer on presence,
// closing drives the closed duty and reports the fill distance, forced open
// stays open until a close command. Throughput is one item per clock while
// out_ready is high; the result of an item is offered on the output in the
// cycle after it is accepted. The rate is set by the combinational step: two
// window compares, two 8-bit decrements and the mode select, all between the
// state registers and the result register. in_ready stays high while the
// result register is empty or being emptied, so a new item is taken in the
// same cycle a result leaves. Configuration is a plain write port; writes take
// effect at once and are meant to be made while no item is in flight.
module proximity_lid_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  plc_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output plc_pkg::out_item_t  out_item,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [9:0]          cfg_data
);

    // configuration registers
    logic [7:0] presence_low_reg;
    logic [7:0] presence_high_reg;
    logic [7:0] confirm_count_reg;
    logic [7:0] hold_ticks_reg;
    logic [9:0] duty_open_reg;
    logic [9:0] duty_closed_reg;

    // lid state
    plc_pkg::lid_mode_t lid_mode_reg, lid_mode_next;
    logic [7:0]         confirm_left_reg, confirm_left_next;
    logic [7:0]         hold_left_reg, hold_left_next;
    logic [9:0]         drive_value_reg, drive_value_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    plc_pkg::out_item_t out_item_reg, out_item_next;

    logic               in_accept;
    logic               present;
    plc_pkg::lid_mode_t cmd_mode;      // mode after the command is applied
    logic               cmd_notify;
    logic [7:0]         confirm_dec;
    logic [7:0]         hold_dec;
    logic               notify;
    logic               fill_valid;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // presence: strictly inside the window; an inverted window never matches
    assign present = (in_item.distance > presence_low_reg)
                  && (in_item.distance < presence_high_reg);

    // remote command stage
    always_comb
    begin
        cmd_mode   = lid_mode_reg;
        cmd_notify = 1'b0;
        priority if (in_item.command == plc_pkg::CMD_OPEN
                     && lid_mode_reg != plc_pkg::MODE_FORCED)
        begin
            cmd_mode   = plc_pkg::MODE_FORCED;
            cmd_notify = 1'b1;
        end
        else if (in_item.command == plc_pkg::CMD_CLOSE
                 && lid_mode_reg != plc_pkg::MODE_CLOSING)
        begin
            cmd_mode = plc_pkg::MODE_CLOSING;
        end
        else
        begin
            cmd_mode = lid_mode_reg;
        end
    end

    // counters wrap modulo 256
    assign confirm_dec = present ? (confirm_left_reg - 8'd1) : confirm_left_reg;
    assign hold_dec    = hold_left_reg - 8'd1;

    // next state
    always_comb
    begin
        lid_mode_next     = cmd_mode;
        confirm_left_next = confirm_left_reg;
        hold_left_next    = hold_left_reg;
        drive_value_next  = drive_value_reg;
        unique case (cmd_mode)
            plc_pkg::MODE_CONFIRM:
            begin
                confirm_left_next = confirm_dec;
                // an exhausted count opens even on a tick without presence
                if (confirm_dec == 8'd0)
                begin
                    lid_mode_next  = plc_pkg::MODE_OPEN;
                    hold_left_next = hold_ticks_reg;
                end
                else if (!present)
                begin
                    lid_mode_next = plc_pkg::MODE_IDLE;
                end
            end
            plc_pkg::MODE_OPEN:
            begin
                drive_value_next = duty_open_reg;
                if (present)
                begin
                    hold_left_next = hold_ticks_reg;
                end
                else
                begin
                    hold_left_next = hold_dec;
                    if (hold_dec == 8'd0)
                    begin
                        lid_mode_next = plc_pkg::MODE_CLOSING;
                    end
                end
            end
            plc_pkg::MODE_CLOSING:
            begin
                drive_value_next = duty_closed_reg;
                lid_mode_next    = plc_pkg::MODE_IDLE;
            end
            plc_pkg::MODE_FORCED:
            begin
                drive_value_next = duty_open_reg;
            end
            default:
            begin
                // idle, and any unreachable code, behaves as idle
                drive_value_next = duty_closed_reg;
                if (present)
                begin
                    lid_mode_next     = plc_pkg::MODE_CONFIRM;
                    confirm_left_next = confirm_count_reg;
                end
                else
                begin
                    lid_mode_next = plc_pkg::MODE_IDLE;
                end
            end
        endcase
    end

    // outputs of the step
    always_comb
    begin
        notify     = cmd_notify;
        fill_valid = 1'b0;
        unique case (cmd_mode)
            plc_pkg::MODE_CONFIRM: notify     = cmd_notify || (confirm_dec == 8'd0);
            plc_pkg::MODE_CLOSING: fill_valid = 1'b1;
            default:               notify     = cmd_notify;
        endcase
    end

    always_comb
    begin
        out_item_next.servo_duty        = drive_value_next;
        out_item_next.notify_open       = notify;
        out_item_next.fill_report_valid = fill_valid;
        out_item_next.fill_distance_out = fill_valid ? in_item.fill_distance_in : 8'd0;
        out_item_next.mode              = lid_mode_next;
    end

    always_comb
    begin
        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // configuration writes; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            presence_low_reg  <= plc_pkg::PRESENCE_LOW_RST;
            presence_high_reg <= plc_pkg::PRESENCE_HIGH_RST;
            confirm_count_reg <= plc_pkg::CONFIRM_COUNT_RST;
            hold_ticks_reg    <= plc_pkg::HOLD_TICKS_RST;
            duty_open_reg     <= plc_pkg::DUTY_OPEN_RST;
            duty_closed_reg   <= plc_pkg::DUTY_CLOSED_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                plc_pkg::REG_PRESENCE_LOW:  presence_low_reg  <= cfg_data[7:0];
                plc_pkg::REG_PRESENCE_HIGH: presence_high_reg <= cfg_data[7:0];
                plc_pkg::REG_CONFIRM_COUNT: confirm_count_reg <= cfg_data[7:0];
                plc_pkg::REG_HOLD_TICKS:    hold_ticks_reg    <= cfg_data[7:0];
                plc_pkg::REG_DUTY_OPEN:     duty_open_reg     <= cfg_data;
                plc_pkg::REG_DUTY_CLOSED:   duty_closed_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // lid state advances once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lid_mode_reg     <= plc_pkg::MODE_IDLE;
            confirm_left_reg <= 8'd0;
            hold_left_reg    <= 8'd0;
            drive_value_reg  <= plc_pkg::DUTY_CLOSED_RST;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                lid_mode_reg     <= lid_mode_next;
                confirm_left_reg <= confirm_left_next;
                hold_left_reg    <= hold_left_next;
                drive_value_reg  <= drive_value_next;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // a fill report always comes with the lid back in idle
    a_fill_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.fill_report_valid
            |-> out_item_reg.mode == plc_pkg::MODE_IDLE)
        else $error("fill report without idle mode");

    // the pending result mirrors the stored state
    a_mode_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_item_reg.mode == lid_mode_reg)
                       && (out_item_reg.servo_duty == drive_value_reg))
        else $error("result does not match lid state");

    // notify only when the lid has just been opened
    a_notify_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.notify_open
            |-> out_item_reg.mode == plc_pkg::MODE_OPEN
             || out_item_reg.mode == plc_pkg::MODE_FORCED)
        else $error("notify without open lid");

    // state only moves on an accepted item
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> $stable(lid_mode_reg) && $stable(hold_left_reg)
                    && $stable(confirm_left_reg))
        else $error("lid state changed without an item");

endmodule
